// ===== hdl/b37c_pkg.sv =====
// Shared types, constants and character mapping functions of the base-37 name codec.
`timescale 1ns / 1ps
package b37c_pkg;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned VAL_W       = 63;
  localparam int unsigned DIG_W       = 6;
  localparam int unsigned POS_W       = 4;

  localparam logic [63:0] RADIX_POW12 = 64'h5b5b57f8a98a5dd1;
  localparam logic [POS_W-1:0] DEC_DIGITS = 4'd12;

  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned DIV_CHUNKS  = 4;
  localparam int unsigned REM_X_W     = DIG_W + CHUNK_W;
  localparam int unsigned PROD_W      = 2 * REM_X_W;
  localparam int unsigned RECIP_SHIFT = 27;
  localparam logic [REM_X_W-1:0] RECIP_M = 22'd3627506;
  localparam logic [REM_X_W-1:0] RADIX_X = 22'd37;
  localparam logic [2:0] DIV_LAST = 3'(2 * DIV_CHUNKS - 1);

  typedef enum logic [1:0] {
    KIND_ENC  = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_BAD  = 2'd2
  } b37c_kind_e;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quot;
    logic [DIG_W-1:0] rem;
  } b37c_div_res_t;

  function automatic logic [DIG_W-1:0] digit_of(input logic [7:0] c);
    logic [DIG_W-1:0] d;
    d = '0;
    case (c) inside
      [8'd65:8'd90]:  d = 6'(c - 8'd64);
      [8'd97:8'd122]: d = 6'(c - 8'd96);
      [8'd48:8'd57]:  d = 6'(c - 8'd21);
      default:        d = '0;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    c = '0;
    case (d) inside
      6'd0:           c = 8'd95;
      [6'd1:6'd26]:   c = {2'b00, d} + 8'd96;
      [6'd27:6'd36]:  c = {2'b00, d} + 8'd21;
      default:        c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/b37c_div37.sv =====
// Iterative divide-by-37 unit: 16-bit chunks, reciprocal multiply and one correction step.
`timescale 1ns / 1ps
module b37c_div37 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [b37c_pkg::VAL_W-1:0] dividend_i,
  output b37c_pkg::b37c_div_res_t    res_o
);
  import b37c_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [2:0]            cnt_q;
  logic [63:0]           num_q;
  logic [VAL_W-1:0]      quot_q;
  logic [DIG_W-1:0]      rem_q;
  logic [PROD_W-1:0]     prod_q;
  logic [PROD_W-1:0]     prod_d;
  logic [REM_X_W-1:0]    x;
  logic [CHUNK_W-1:0]    q0;
  logic [REM_X_W-1:0]    q0_ext;
  logic [REM_X_W-1:0]    r0;
  logic [CHUNK_W-1:0]    q_fix;
  logic [DIG_W-1:0]      r_fix;

  assign x      = {rem_q, num_q[63 -: CHUNK_W]};
  assign prod_d = PROD_W'(x) * PROD_W'(RECIP_M);
  assign q0     = prod_q[RECIP_SHIFT +: CHUNK_W];
  assign q0_ext = REM_X_W'(q0);
  assign r0     = x - ((q0_ext << 5) + (q0_ext << 2) + q0_ext);

  always_comb begin
    if (r0 >= RADIX_X) begin
      q_fix = q0 + CHUNK_W'(1);
      r_fix = DIG_W'(r0 - RADIX_X);
    end else begin
      q_fix = q0;
      r_fix = r0[DIG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == DIV_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {1'b0, dividend_i};
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      if (!cnt_q[0]) begin
        prod_q <= prod_d;
      end else begin
        quot_q <= {quot_q[VAL_W-1-CHUNK_W:0], q_fix};
        rem_q  <= r_fix;
        num_q  <= {num_q[63-CHUNK_W:0], CHUNK_W'(0)};
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

// ===== hdl/base37_name_codec.sv =====
// Top level of the base-37 name codec: stream ports, sequencer, accumulator and digit store.
`timescale 1ns / 1ps
// Encode requests (tuser 0) carry one character each and are taken one per cycle; a
// request with tlast set closes the name, and the block then strips trailing underscores
// with the shared divide-by-37 unit before it offers the packed value. Decode requests
// (tuser 1) run the same unit once per digit and then emit one result per character; a
// value that is out of range gives one invalid result, as does one with a zero low digit.
// The input is not ready while a name is being stripped or a value decoded; a finished
// result waits in the output register.
module base37_name_codec_core #(
  parameter int unsigned MAX_CHARS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [7:0] char_code, [71:8] packed_value
  input  logic [b37c_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [0] mode
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tlast_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [62:0] packed_out, [70:63] char_out, [74:71] char_position, [79:75] zero
  output logic [b37c_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import b37c_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_CHARS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_WAIT  = 5'b00100,
    S_EMIT  = 5'b01000,
    S_PUT   = 5'b10000
  } b37c_state_e;

  b37c_state_e     state_q;
  logic [VAL_W-1:0] run_q, run_d;
  logic [CntW-1:0]  ccnt_q, ccnt_d;
  logic             ended_q, ended_d;
  logic [VAL_W-1:0] work_q;
  logic             dec_q;
  logic             bad_q;
  logic [POS_W-1:0] ndig_q;
  logic [POS_W-1:0] pos_q;
  logic [DIG_W-1:0] dig_q [DEC_DIGITS];

  logic             out_valid_q;
  b37c_kind_e       out_kind_q;
  logic [VAL_W-1:0] out_packed_q;
  logic [7:0]       out_char_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_last_q;

  b37c_div_res_t    div_res;
  logic             s_fire;
  logic             out_free;
  logic [7:0]       in_char;
  logic [63:0]      in_raw;
  logic             raw_bad;
  logic [DIG_W-1:0] in_dig;
  logic [POS_W-1:0] emit_idx;
  logic             emit_load;
  logic             put_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_char         = s_axis_tdata_i[7:0];
  assign in_raw          = s_axis_tdata_i[71:8];
  assign in_dig          = digit_of(in_char);
  assign raw_bad         = in_raw[63] || (in_raw == 64'd0) || (in_raw >= RADIX_POW12);
  assign emit_idx        = ndig_q - POS_W'(1);
  assign emit_load       = (state_q == S_EMIT) && out_free;
  assign put_load        = (state_q == S_PUT) && out_free;

  b37c_div37 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (work_q),
    .res_o      (div_res)
  );

  always_comb begin
    run_d   = run_q;
    ccnt_d  = ccnt_q;
    ended_d = ended_q;
    if (!ended_q && (ccnt_q < CntW'(MAX_CHARS))) begin
      if (in_char == 8'd0) begin
        ended_d = 1'b1;
      end else begin
        run_d  = (run_q << 5) + (run_q << 2) + run_q + VAL_W'(in_dig);
        ccnt_d = ccnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q   <= '0;
      ccnt_q  <= '0;
      ended_q <= 1'b0;
      work_q  <= '0;
      dec_q   <= 1'b0;
      bad_q   <= 1'b0;
      ndig_q  <= '0;
      pos_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_fire && !s_axis_tuser_i) begin
            if (s_axis_tlast_i) begin
              work_q  <= run_d;
              run_q   <= '0;
              ccnt_q  <= '0;
              ended_q <= 1'b0;
              dec_q   <= 1'b0;
              bad_q   <= 1'b0;
              state_q <= S_START;
            end else begin
              run_q   <= run_d;
              ccnt_q  <= ccnt_d;
              ended_q <= ended_d;
            end
          end else if (s_fire) begin
            dec_q  <= 1'b1;
            ndig_q <= '0;
            if (raw_bad) begin
              bad_q   <= 1'b1;
              state_q <= S_PUT;
            end else begin
              work_q  <= in_raw[VAL_W-1:0];
              state_q <= S_START;
            end
          end
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_res.done) begin
            if (!dec_q) begin
              if ((work_q != '0) && (div_res.rem == '0)) begin
                work_q  <= div_res.quot;
                state_q <= S_START;
              end else begin
                state_q <= S_PUT;
              end
            end else if ((ndig_q == '0) && (div_res.rem == '0)) begin
              bad_q   <= 1'b1;
              state_q <= S_PUT;
            end else begin
              ndig_q <= ndig_q + POS_W'(1);
              work_q <= div_res.quot;
              if ((div_res.quot != '0) && (ndig_q < DEC_DIGITS - POS_W'(1))) begin
                state_q <= S_START;
              end else begin
                pos_q   <= '0;
                state_q <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            ndig_q <= emit_idx;
            pos_q  <= pos_q + POS_W'(1);
            if (ndig_q == POS_W'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_PUT: begin
          if (put_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_WAIT) && div_res.done && dec_q) begin
      dig_q[ndig_q] <= div_res.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load || put_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      out_kind_q   <= KIND_CHAR;
      out_packed_q <= '0;
      out_char_q   <= digit_char(dig_q[emit_idx]);
      out_pos_q    <= pos_q;
      out_last_q   <= (ndig_q == POS_W'(1));
    end else if (put_load) begin
      out_kind_q   <= bad_q ? KIND_BAD : KIND_ENC;
      out_packed_q <= bad_q ? '0 : work_q;
      out_char_q   <= '0;
      out_pos_q    <= '0;
      out_last_q   <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {5'd0, out_pos_q, out_char_q, out_packed_q};

endmodule

// ===== hdl/b37c_checker.sv =====
// Port-level checks of the base-37 name codec, bound to the top level.
`timescale 1ns / 1ps
module b37c_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [b37c_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                             s_axis_tuser_i,
  input logic                             s_axis_tlast_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [b37c_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]                       m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);
  import b37c_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("result request changed while stalled");

  a_decode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i |=> !s_axis_tready_o)
    else $error("decode request did not stall the input");

  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_BAD) |->
      m_axis_tlast_o && (m_axis_tdata_o == '0))
    else $error("invalid result carries data or is not last");

  a_enc_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_ENC) |->
      m_axis_tlast_o && (m_axis_tdata_o[79:63] == '0))
    else $error("encoded result carries character fields or is not last");

  a_char_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == KIND_CHAR) |->
      (m_axis_tdata_o[62:0] == '0) && (m_axis_tdata_o[74:71] < DEC_DIGITS))
    else $error("decoded character result malformed");

endmodule

bind base37_name_codec_core b37c_checker u_b37c_checker (.*);
